// File: sv/soe_pkg.sv
// Package for the stack operator evaluator: sizes, opcodes, status codes,
// controller states and the command/status structs between controller and datapath.
package soe_pkg;
  localparam int StackDepth = 16;
  localparam int WordWidth = 32;
  localparam int AddrW = $clog2(StackDepth);
  localparam int CntW = $clog2(StackDepth + 1);

  typedef logic [WordWidth-1:0] word_t;

  typedef enum logic [4:0] {
    OP_INC = 5'd0, OP_DEC = 5'd1, OP_NOT = 5'd2, OP_NEG = 5'd3,
    OP_DIV = 5'd4, OP_SUB = 5'd5, OP_MUL = 5'd6, OP_ADD = 5'd7,
    OP_MOD = 5'd8, OP_POW = 5'd9, OP_LE = 5'd10, OP_LT = 5'd11,
    OP_GE = 5'd12, OP_GT = 5'd13, OP_NE = 5'd14, OP_EQ = 5'd15,
    OP_AND = 5'd16, OP_OR = 5'd17
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_DIVZ = 2'd1, ST_UNDER = 2'd2, ST_OVER = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_B, S_RD_A, S_LD_A, S_EXEC, S_ITER, S_WRITE, S_RD_TOP,
    S_LD_TOP, S_OUT
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic       capture;   // latch the request fields
    logic       rd_b;      // read entry count-1 into b
    logic       rd_a;      // read entry count-2 into a
    logic       ld_a;      // take the read data into a
    logic       start;     // set up the operator
    logic       iter;      // one divide or power step
    logic       write;     // write answer or pushed value, update count
    logic       rd_top;    // take the top of stack into the result
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic       is_push;
    logic       unary;
    logic       binary;
    logic       iterative;
    logic       iter_done;
    logic       fault;     // error found, stack left unchanged
  } stat_t;
endpackage

// File: sv/soe_datapath.sv
// Datapath of the stack operator evaluator: stack memory, count, operand
// registers, shared divide/power step unit and result register. Uses soe_pkg.
module soe_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  soe_pkg::cmd_t        cmd,
  output soe_pkg::stat_t       stat,
  input  logic                 in_kind,
  input  logic [4:0]           in_opcode,
  input  logic signed [31:0]   in_operand_value,
  output logic signed [31:0]   res_value,
  output logic [1:0]           res_status,
  output logic [4:0]           res_depth
);
  import soe_pkg::*;

  localparam int IterW = $clog2(WordWidth + 1);

  word_t mem [StackDepth];
  word_t rd_data_r;
  logic [CntW-1:0] count_r, count_nxt;
  logic kind_r;
  logic [4:0] op_r;
  word_t val_r, a_r, b_r;
  logic [1:0] status_r, status_nxt;
  // Iteration registers: remainder/quotient for divide, acc/square for power.
  word_t acc_r, acc_nxt, sq_r, sq_nxt, ex_r, ex_nxt;
  logic [IterW-1:0] it_r, it_nxt;
  word_t ans_r, ans_nxt;

  logic [CntW-1:0] cm1, cm2;
  assign cm1 = count_r - CntW'(1);
  assign cm2 = count_r - CntW'(2);

  logic sa, sb;
  word_t ma, mb;
  assign sa = a_r[WordWidth-1];
  assign sb = b_r[WordWidth-1];
  assign ma = sa ? -a_r : a_r;
  assign mb = sb ? -b_r : b_r;

  logic is_div;
  assign is_div = (op_r == OP_DIV) || (op_r == OP_MOD);

  always_comb begin
    stat.is_push   = !kind_r;
    stat.unary     = kind_r && op_r <= OP_NEG;
    stat.binary    = kind_r && op_r >= OP_DIV && op_r <= OP_OR;
    stat.iterative = kind_r && (is_div || op_r == OP_POW);
    stat.iter_done = (it_r == IterW'(WordWidth));
    stat.fault     = (status_r != ST_OK);
  end

  // One step: restoring divide bit, or square-and-multiply bit.
  logic [WordWidth:0] trial;
  word_t rem_sh;
  always_comb begin
    acc_nxt = acc_r; sq_nxt = sq_r; ex_nxt = ex_r; it_nxt = it_r;
    rem_sh = {acc_r[WordWidth-2:0], sq_r[WordWidth-1]};
    trial = {1'b0, rem_sh} - {1'b0, mb};
    if (cmd.start) begin
      it_nxt = '0;
      if (is_div) begin
        acc_nxt = '0; sq_nxt = ma; ex_nxt = '0;
      end else begin
        acc_nxt = word_t'(1); sq_nxt = a_r; ex_nxt = b_r;
      end
    end else if (cmd.iter) begin
      it_nxt = it_r + IterW'(1);
      if (is_div) begin
        if (!trial[WordWidth]) acc_nxt = trial[WordWidth-1:0];
        else acc_nxt = rem_sh;
        sq_nxt = {sq_r[WordWidth-2:0], !trial[WordWidth]};
      end else begin
        if (ex_r[0]) acc_nxt = word_t'(acc_r * sq_r);
        sq_nxt = word_t'(sq_r * sq_r);
        ex_nxt = ex_r >> 1;
      end
    end
  end

  // Answer for the write step.
  logic slt;
  assign slt = $signed(a_r) < $signed(b_r);
  always_comb begin
    ans_nxt = ans_r;
    status_nxt = status_r;
    if (cmd.capture) status_nxt = ST_OK;
    if (cmd.start) begin
      if (!kind_r) begin
        if (count_r >= CntW'(StackDepth)) status_nxt = ST_OVER;
      end else if (op_r <= OP_NEG) begin
        if (count_r < CntW'(1)) status_nxt = ST_UNDER;
      end else if (op_r <= OP_OR) begin
        if (count_r < CntW'(2)) status_nxt = ST_UNDER;
        else if (is_div && b_r == '0) status_nxt = ST_DIVZ;
      end
      unique case (op_r)
        OP_INC: ans_nxt = b_r + word_t'(1);
        OP_DEC: ans_nxt = b_r - word_t'(1);
        OP_NOT: ans_nxt = word_t'(b_r == '0);
        OP_NEG: ans_nxt = -b_r;
        OP_SUB: ans_nxt = a_r - b_r;
        OP_MUL: ans_nxt = word_t'(a_r * b_r);
        OP_ADD: ans_nxt = a_r + b_r;
        OP_LE:  ans_nxt = word_t'(!($signed(b_r) < $signed(a_r)));
        OP_LT:  ans_nxt = word_t'(slt);
        OP_GE:  ans_nxt = word_t'(!slt);
        OP_GT:  ans_nxt = word_t'($signed(b_r) < $signed(a_r));
        OP_NE:  ans_nxt = word_t'(a_r != b_r);
        OP_EQ:  ans_nxt = word_t'(a_r == b_r);
        OP_AND: ans_nxt = word_t'(a_r != '0 && b_r != '0);
        OP_OR:  ans_nxt = word_t'(a_r != '0 || b_r != '0);
        default: ans_nxt = '0;
      endcase
      if (!kind_r) ans_nxt = val_r;
    end else if (cmd.iter && stat.iter_done) begin
      // Final fix-up of sign and power special cases.
      if (op_r == OP_DIV) ans_nxt = (sa ^ sb) ? -sq_r : sq_r;
      else if (op_r == OP_MOD) ans_nxt = sa ? -acc_r : acc_r;
      else if (sb) begin
        if (a_r == word_t'(1)) ans_nxt = word_t'(1);
        else if (a_r == '1) ans_nxt = b_r[0] ? '1 : word_t'(1);
        else ans_nxt = '0;
      end else ans_nxt = acc_r;
    end
  end

  logic [CntW-1:0] wr_idx;
  always_comb begin
    count_nxt = count_r;
    wr_idx = cm1;
    if (cmd.write && status_r == ST_OK) begin
      if (!kind_r) begin
        count_nxt = count_r + CntW'(1); wr_idx = count_r;
      end else if (op_r >= OP_DIV && op_r <= OP_OR) begin
        count_nxt = cm1; wr_idx = cm2;
      end
    end
  end

  logic [CntW-1:0] rd_idx;
  always_comb begin
    if (cmd.rd_b) rd_idx = cm1;
    else if (cmd.rd_a) rd_idx = cm2;
    else rd_idx = cm1;
  end

  always_ff @(posedge clk) begin
    if (cmd.write && status_r == ST_OK &&
        (!kind_r || op_r <= OP_OR)) mem[wr_idx[AddrW-1:0]] <= ans_r;
    rd_data_r <= mem[rd_idx[AddrW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_kind;
      op_r <= in_opcode;
      val_r <= word_t'(in_operand_value);
    end
    // Read data is registered, so it lands in the cycle after the address is given.
    if (cmd.rd_a) b_r <= rd_data_r;
    if (cmd.ld_a) a_r <= rd_data_r;
    acc_r <= acc_nxt; sq_r <= sq_nxt; ex_r <= ex_nxt; it_r <= it_nxt;
    ans_r <= ans_nxt;
    status_r <= status_nxt;
    if (cmd.rd_top) res_value <= 32'((count_r == '0) ? '0 : rd_data_r);
    res_status <= status_r;
    res_depth <= 5'(count_r);
  end
endmodule

// File: sv/soe_ctrl.sv
// Controller of the stack operator evaluator: sequences reads, operator
// steps, the stack write and the result hand-off. Uses soe_pkg.
module soe_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output soe_pkg::cmd_t   cmd,
  input  soe_pkg::stat_t  stat
);
  import soe_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_RD_B;
      S_RD_B:   state_nxt = S_RD_A;
      S_RD_A:   state_nxt = S_LD_A;
      S_LD_A:   state_nxt = S_EXEC;
      S_EXEC:   state_nxt = (stat.iterative && stat.binary) ? S_ITER : S_WRITE;
      S_ITER:   if (stat.fault || stat.iter_done) state_nxt = S_WRITE;
      S_WRITE:  state_nxt = S_RD_TOP;
      S_RD_TOP: state_nxt = S_LD_TOP;
      S_LD_TOP: state_nxt = S_OUT;
      S_OUT:    if (out_ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // The top-of-stack read is issued in S_RD_TOP and its data registered in S_LD_TOP.
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE:   begin in_ready = 1'b1; cmd.capture = in_valid; end
      S_RD_B:   cmd.rd_b = 1'b1;
      S_RD_A:   cmd.rd_a = 1'b1;
      S_LD_A:   cmd.ld_a = 1'b1;
      S_EXEC:   cmd.start = 1'b1;
      S_ITER:   cmd.iter = 1'b1;
      S_WRITE:  cmd.write = 1'b1;
      S_RD_TOP: ;
      S_LD_TOP: cmd.rd_top = 1'b1;
      S_OUT:    out_valid = 1'b1;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end
endmodule

// File: sv/stack_operator_evaluator_core.sv
// Top level of the stack operator evaluator; joins soe_ctrl and soe_datapath.
// Depends on soe_pkg.
//
//  channel | direction | handshake            | fields
//  in      | input     | in_valid / in_ready  | kind, opcode, operand_value
//  out     | output    | out_valid / out_ready| result_value, status, depth_after
//
// A push or simple operator passes through S_RD_B, S_RD_A, S_LD_A, S_EXEC, S_WRITE,
// S_RD_TOP and S_LD_TOP before its result is offered in S_OUT; divide, modulo
// and power also step the shared shift/multiply unit in S_ITER, which is left
// early when the operator faults.
// Synchronous active-low reset empties the stack; entries are not cleared.
// One request is in flight; a stalled result holds until out_ready.
module stack_operator_evaluator_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_kind,
  input  logic [4:0]          in_opcode,
  input  logic signed [31:0]  in_operand_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_result_value,
  output logic [1:0]          out_status,
  output logic [4:0]          out_depth_after
);
  import soe_pkg::*;

  cmd_t cmd;
  stat_t stat;

  soe_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .cmd, .stat
  );

  soe_datapath u_dp (
    .clk, .rst_n, .cmd, .stat,
    .in_kind, .in_opcode, .in_operand_value,
    .res_value(out_result_value), .res_status(out_status),
    .res_depth(out_depth_after)
  );
endmodule

// File: sv/soe_checker.sv
// Port-level checker for stack_operator_evaluator_core and its bind.
// Depends only on the top-level ports.
module soe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [4:0]  out_depth_after
);
  a_one_sided: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_depth_after) &&
    $stable(out_status))
    else $error("result dropped");
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_depth_after <= 5'd16) else $error("depth too large");
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid) else $error("result too early");
endmodule

bind stack_operator_evaluator_core soe_checker u_chk (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
  .out_status, .out_depth_after
);
